// ===== rtl/core/pcd_pkg.sv =====
// Package for the point-to-center distance block.
// Holds the sizes, the field widths and the control bundle that drives the cell row.
// No dependencies.
package pcd_pkg;

  localparam int unsigned MaxCenters = 8;
  localparam int unsigned MaxDims    = 16;
  localparam int unsigned CoordBits  = 16;

  localparam int unsigned CenterW = $clog2(MaxCenters);
  localparam int unsigned DimW    = $clog2(MaxDims);
  localparam int unsigned AccW    = 37;
  localparam int unsigned SqdW    = 36;
  localparam int unsigned RootW   = 18;
  localparam int unsigned MagW    = CoordBits;
  localparam int unsigned SqW     = 2 * MagW;

  // Configuration register indexes.
  localparam logic [1:0] RegCenters = 2'd0;
  localparam logic [1:0] RegDims    = 2'd1;

  // Step enables shared by every cell of the row.
  typedef struct packed {
    logic diff_en;
    logic sq_en;
    logic acc_en;
    logic shift;
  } pcd_ctl_t;

endpackage

// ===== rtl/core/point_center_distance.sv =====
// Euclidean distance from streamed points to up to eight loaded cluster centers.
// Items with tuser 0 load a center coordinate. A point coordinate (tuser 1) passes
// through the input, difference, square and accumulate steps that the cell row runs in
// turn. After the coordinate marked tlast, the block reads the accumulators out of the
// row one cell a cycle while no square root or output wait holds it, and sends one item
// per active center; each item starts the bit-serial square root, waits for it and is
// then presented until the output takes it, and inactive cells are shifted past with no
// item.
// Depends on pcd_pkg, pcd_cell and pcd_sqrt.
module point_center_distance
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // center_index[2:0], dim_index[6:3], value[22:7], zero pad
  input  logic        s_tuser,   // kind
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_center[2:0], squared_distance[38:3],
                                 // distance[56:39], zero pad
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIFF, S_SQ, S_ACC, S_EMIT, S_ROOT, S_OUT
  } state_t;

  state_t                      state;
  logic [3:0]                  centers_reg;
  logic [4:0]                  dims_reg;
  logic [3:0]                  ncent;
  logic [4:0]                  ndims;
  logic [DimW-1:0]             dim_q;
  logic signed [CoordBits-1:0] val_q;
  logic                        last_q;
  logic [CenterW-1:0]          k;
  logic                        in_acc;
  logic                        load_we;
  pcd_ctl_t                    ctl;
  logic [AccW-1:0]             accs [MaxCenters];
  logic [SqdW-1:0]             head_sat;
  logic [SqdW-1:0]             sqd_q;
  logic                        root_start;
  logic                        root_done;
  logic [RootW-1:0]            root;
  logic [CenterW-1:0]          oc;
  logic [SqdW-1:0]             osqd;
  logic [RootW-1:0]            odist;

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_we   = in_acc && !s_tuser;

  // Register counts clamped to their legal ranges.
  assign ncent = (centers_reg == 4'd0) ? 4'd1 :
                 (centers_reg > 4'(MaxCenters)) ? 4'(MaxCenters) : centers_reg;
  assign ndims = (dims_reg == 5'd0) ? 5'd1 :
                 (dims_reg > 5'(MaxDims)) ? 5'(MaxDims) : dims_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      centers_reg <= 4'(MaxCenters);
      dims_reg    <= 5'(MaxDims);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegCenters) begin
        centers_reg <= cfg_data[3:0];
      end else if (cfg_index == RegDims) begin
        dims_reg <= cfg_data;
      end
    end
  end

  // Step enables for the cell row.
  assign ctl.diff_en = (state == S_DIFF);
  assign ctl.sq_en   = (state == S_SQ);
  assign ctl.acc_en  = (state == S_ACC) && ({1'b0, dim_q} < ndims);
  assign ctl.shift   = (state == S_EMIT);

  // The row of center cells; sums move toward cell zero during read-out.
  for (genvar c = 0; c < MaxCenters; c++) begin : g_cell
    logic [AccW-1:0] nbr;
    if (c == MaxCenters - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = accs[c+1];
    end
    pcd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load_we  (load_we && (s_tdata[2:0] == CenterW'(c))),
      .load_dim (s_tdata[6:3]),
      .load_val (s_tdata[22:7]),
      .rd_dim   (dim_q),
      .point_val(val_q),
      .ctl      (ctl),
      .active   (4'(c) < ncent),
      .acc_in   (nbr),
      .acc      (accs[c])
    );
  end

  assign head_sat   = (accs[0][AccW-1]) ? {SqdW{1'b1}} : accs[0][SqdW-1:0];
  assign root_start = (state == S_EMIT) && ({1'b0, k} < ncent);

  pcd_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(root_start),
    .din  (head_sat),
    .done (root_done),
    .root (root)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      k        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && s_tuser) begin
            dim_q  <= s_tdata[6:3];
            val_q  <= s_tdata[22:7];
            last_q <= s_tlast;
            state  <= S_DIFF;
          end
        end
        S_DIFF: state <= S_SQ;
        S_SQ:   state <= S_ACC;
        S_ACC: begin
          k     <= '0;
          state <= last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (root_start) begin
            sqd_q <= head_sat;
            state <= S_ROOT;
          end else if (k == CenterW'(MaxCenters - 1)) begin
            state <= S_IDLE;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            m_tvalid <= 1'b1;
            oc       <= k;
            osqd     <= sqd_q;
            odist    <= root;
            m_tlast  <= ({1'b0, k} == ncent - 4'd1);
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (k == CenterW'(MaxCenters - 1)) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, odist, osqd, oc};

endmodule

// ===== rtl/core/pcd_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on pcd_pkg.
module pcd_sqrt
  import pcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SqdW-1:0]  din,
  output logic             done,
  output logic [RootW-1:0] root
);

  logic [SqdW-1:0]    rad;
  logic [RootW+1:0]   rem;
  logic [4:0]         cnt;
  logic               busy;
  logic [RootW+1:0]   rem_sh;
  logic [RootW+1:0]   trial;

  // One restoring step: bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem[RootW-1:0], rad[SqdW-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= din;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[SqdW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RootW-2:0], 1'b0};
        end
        if (cnt == 5'(RootW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

endmodule

// ===== rtl/core/pcd_cell.sv =====
// One center cell: holds the center's coordinates and its running squared distance.
// Accumulators pass toward cell zero when results are read out. Depends on pcd_pkg.
module pcd_cell
  import pcd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load_we,
  input  logic [DimW-1:0]             load_dim,
  input  logic signed [CoordBits-1:0] load_val,
  input  logic [DimW-1:0]             rd_dim,
  input  logic signed [CoordBits-1:0] point_val,
  input  pcd_ctl_t                    ctl,
  input  logic                        active,
  input  logic [AccW-1:0]             acc_in,
  output logic [AccW-1:0]             acc
);

  logic signed [CoordBits-1:0] coords [MaxDims];
  logic signed [CoordBits:0]   diff;
  logic [MagW-1:0]             mag;
  logic [SqW-1:0]              sq;
  logic [AccW:0]               sum;

  // Center coordinate store, one entry per dimension.
  always_ff @(posedge clk) begin
    if (load_we) begin
      coords[load_dim] <= load_val;
    end
  end

  // Difference, then square, each registered.
  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      diff <= {point_val[CoordBits-1], point_val} - {coords[rd_dim][CoordBits-1], coords[rd_dim]};
    end
    if (ctl.sq_en) begin
      sq <= mag * mag;
    end
  end

  assign mag = diff[CoordBits] ? MagW'(-diff) : MagW'(diff);
  assign sum = {{(AccW + 1 - SqW){1'b0}}, sq} + {1'b0, acc};

  // Saturating accumulator; read-out shifts the neighbor's sum in.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= acc_in;
    end else if (ctl.acc_en && active) begin
      acc <= sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];
    end
  end

endmodule

// ===== rtl/core/pcd_checker.sv =====
// Port-level checks for point_center_distance, bound to the top level.
// Depends on pcd_pkg for field widths.
module pcd_checker
  import pcd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  logic [SqdW-1:0]  sqd;
  logic [RootW-1:0] root_val;
  logic [2*RootW+1:0] lo_sq;
  logic [2*RootW+1:0] hi_sq;

  assign sqd      = m_tdata[SqdW+2:3];
  assign root_val = m_tdata[SqdW+RootW+2:SqdW+3];
  assign lo_sq    = (2*RootW+2)'(root_val) * (2*RootW+2)'(root_val);
  assign hi_sq    = ((2*RootW+2)'(root_val) + 1) * ((2*RootW+2)'(root_val) + 1);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No input is taken while a result waits.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted during read-out");

  // The distance is the floor root of the squared distance.
  a_root: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (lo_sq <= (2*RootW+2)'(sqd)) && (hi_sq > (2*RootW+2)'(sqd)))
    else $error("distance is not the floor root");

  // Nothing is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind point_center_distance pcd_checker u_pcd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
